// ===== design/mcfe_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfe_pkg
// Shared types and constants of the motor command frame encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mcfe_pkg;

  // Command codes
  typedef enum logic [3:0] {
    CMD_ENABLE    = 4'd0,
    CMD_DISABLE   = 4'd1,
    CMD_ZERO      = 4'd2,
    CMD_IDLE      = 4'd3,
    CMD_MIT       = 4'd4,
    CMD_POSVEL    = 4'd5,
    CMD_VEL       = 4'd6,
    CMD_POSTORQUE = 4'd7,
    CMD_READ      = 4'd8,
    CMD_WRITE     = 4'd9,
    CMD_SAVE      = 4'd10
  } cmd_t;

  // Configuration register indexes
  localparam logic [7:0] CFG_NODE_ID        = 8'd0;
  localparam logic [7:0] CFG_POSITION_LIMIT = 8'd1;
  localparam logic [7:0] CFG_VELOCITY_LIMIT = 8'd2;
  localparam logic [7:0] CFG_TORQUE_LIMIT   = 8'd3;

  localparam int LIM_W   = 25;
  localparam int DEN_W   = 26;
  localparam int QUO_W   = 16;
  localparam int NUM_W   = DEN_W + QUO_W;
  localparam int DIV_STEPS = QUO_W;

  localparam logic [DEN_W-1:0] KP_MAX = 26'd32768000;
  localparam logic [DEN_W-1:0] KD_MAX = 26'd327680;
  localparam logic [QUO_W-1:0] MAXC16 = 16'hFFFF;
  localparam logic [QUO_W-1:0] MAXC12 = 16'h0FFF;

  // Reciprocals of 125 (scaled by 2^26) and 5 (scaled by 2^18), rounded up;
  // KP_MAX is 125 * 2^18 and KD_MAX is 5 * 2^16
  localparam logic [19:0] KP_RECIP = 20'd536871;
  localparam logic [15:0] KD_RECIP = 16'd52429;

  localparam logic [10:0] ID_BCAST     = 11'h7FF;
  localparam logic [10:0] ID_POSVEL    = 11'h100;
  localparam logic [10:0] ID_VEL       = 11'h200;
  localparam logic [10:0] ID_POSTORQUE = 11'h300;

  localparam logic [7:0] OP_READ  = 8'h33;
  localparam logic [7:0] OP_WRITE = 8'h55;
  localparam logic [7:0] OP_SAVE  = 8'hAA;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] torque;
    logic signed [31:0] stiffness;
    logic signed [31:0] damping;
    logic [7:0]         param_reg;
    logic [31:0]        param_value;
  } in_t;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [63:0] frame_payload;
  } out_t;

endpackage
`default_nettype wire

// ===== design/motor_command_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// motor_command_frame_encoder
// Builds one CAN frame (11-bit id, 8 payload bytes) per motor command.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and pulse start; a command is taken at every edge
//   with start high and busy low. busy stays low, so a command may be
//   issued every cycle.
//   Output: each frame appears on out_data for one cycle with out_valid high,
//   in command order. The receiver cannot stall; frames are never held back.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
//   node id, position, velocity or torque limit; cfg_ready is always high.
//   Write only while no frame is in flight.
//   Throughput: one frame per cycle. Latency is set by the 16-stage
//   pipelined divider that scales the MIT-mode position, velocity and
//   torque codes.
//   Reset: rst_n low clears all in-flight frames and restores the default
//   node id and limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module motor_command_frame_encoder
  import mcfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_t         in_data,
  output logic             out_valid,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int DLY = DIV_STEPS - 2;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [7:0]  nd;
    logic [7:0]  preg;
    logic [31:0] pval;
  } ctl_t;

  typedef struct packed {
    logic        mit;
    logic [11:0] kp;
    logic [11:0] kd;
    logic [10:0] id;
    logic [63:0] pay;
  } side_t;

  // Configuration registers
  logic [7:0]       node_id_r;
  logic [LIM_W-1:0] lp_r, lv_r, lt_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= 8'd1;
      lp_r      <= 25'd819200;
      lv_r      <= 25'd1966080;
      lt_r      <= 25'd655360;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NODE_ID:        node_id_r <= cfg_data[7:0];
        CFG_POSITION_LIMIT: lp_r      <= cfg_data[LIM_W-1:0];
        CFG_VELOCITY_LIMIT: lv_r      <= cfg_data[LIM_W-1:0];
        CFG_TORQUE_LIMIT:   lt_r      <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [DEN_W-1:0] clamp_sym(logic signed [31:0] x,
                                                        logic [LIM_W-1:0] l);
    logic signed [32:0] xs, ls;
    xs = {x[31], x};
    ls = $signed({8'b0, l});
    if (xs > ls)       return DEN_W'(ls);
    else if (xs < -ls) return DEN_W'(-ls);
    else               return DEN_W'(xs);
  endfunction

  function automatic logic [DEN_W-1:0] clamp_pos(logic signed [31:0] x,
                                                 logic [DEN_W-1:0] l);
    if (x < 0)                          return '0;
    else if (x > $signed({6'b0, l}))    return l;
    else                                return x[DEN_W-1:0];
  endfunction

  function automatic logic [31:0] le_word(logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Stage 1: clamp and offset
  logic [3:0] vld_r;
  ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r;
  logic signed [DEN_W-1:0] pc1_r, vc1_r;
  logic [DEN_W-1:0] np1_r, nv1_r, nt1_r, nkp1_r, nkd1_r;
  logic [DEN_W-1:0] dp1_r, dv1_r, dt1_r;
  logic [LIM_W-1:0] vz1_r, tz1_r;

  always_ff @(posedge clk) begin
    logic signed [DEN_W-1:0] tc;
    tc     = clamp_sym(in_data.torque, lt_r);
    ctl1_r <= '{cmd: in_data.cmd, nd: node_id_r, preg: in_data.param_reg,
                pval: in_data.param_value};
    pc1_r  <= clamp_sym(in_data.position, lp_r);
    vc1_r  <= clamp_sym(in_data.velocity, lv_r);
    np1_r  <= DEN_W'(clamp_sym(in_data.position, lp_r) + $signed({1'b0, lp_r}));
    nv1_r  <= DEN_W'(clamp_sym(in_data.velocity, lv_r) + $signed({1'b0, lv_r}));
    nt1_r  <= DEN_W'(tc + $signed({1'b0, lt_r}));
    nkp1_r <= clamp_pos(in_data.stiffness, KP_MAX);
    nkd1_r <= clamp_pos(in_data.damping, KD_MAX);
    dp1_r  <= {lp_r, 1'b0};
    dv1_r  <= {lv_r, 1'b0};
    dt1_r  <= {lt_r, 1'b0};
    vz1_r  <= LIM_W'(clamp_pos(in_data.velocity, {1'b0, lv_r}));
    tz1_r  <= LIM_W'(clamp_pos(in_data.torque, {1'b0, lt_r}));
  end

  // Stage 2: scale numerators, postorque limits
  logic [NUM_W-1:0] mp2_r, mv2_r, mt2_r;
  logic [18:0]      akp2_r;
  logic [14:0]      akd2_r;
  logic [DEN_W-1:0] dp2_r, dv2_r, dt2_r;
  logic [15:0]      vl2_r, il2_r, vl3_r, il3_r, vl4_r, il4_r;

  always_ff @(posedge clk) begin
    logic [31:0] pv;
    logic [38:0] pi;
    logic [37:0] mk;
    logic [37:0] md;
    pv = 32'(vz1_r) * 32'd100;
    pi = 39'(tz1_r) * 39'd10000;
    mk = 38'(nkp1_r) * 38'(MAXC12);
    md = 38'(nkd1_r) * 38'(MAXC12);
    mp2_r  <= NUM_W'(np1_r) * NUM_W'(MAXC16);
    mv2_r  <= NUM_W'(nv1_r) * NUM_W'(MAXC12);
    mt2_r  <= NUM_W'(nt1_r) * NUM_W'(MAXC12);
    akp2_r <= mk[36:18];
    akd2_r <= md[30:16];
    dp2_r  <= dp1_r;
    dv2_r  <= dv1_r;
    dt2_r  <= dt1_r;
    vl2_r  <= pv[31:16];
    il2_r  <= (pi[38:32] != '0) ? 16'hFFFF : pi[31:16];
    vl3_r  <= vl2_r;
    il3_r  <= il2_r;
    vl4_r  <= vl3_r;
    il4_r  <= il3_r;
    ctl2_r <= ctl1_r;
    ctl3_r <= ctl2_r;
    ctl4_r <= ctl3_r;
  end

  // Stage 3: gain codes, divide by 125 and by 5 through reciprocals
  logic [11:0] kp3_r, kd3_r, kp4_r, kd4_r;
  always_ff @(posedge clk) begin
    logic [39:0] pp;
    logic [31:0] pd;
    pp = 40'(akp2_r) * 40'(KP_RECIP);
    pd = 32'(akd2_r) * 32'(KD_RECIP);
    kp3_r <= pp[37:26];
    kd3_r <= pd[29:18];
    kp4_r <= kp3_r;
    kd4_r <= kd3_r;
  end

  // Float conversions, three stages
  logic [31:0] fp4, fv4;
  mcfe_f32 u_fp (.clk(clk), .x(pc1_r), .f(fp4));
  mcfe_f32 u_fv (.clk(clk), .x(vc1_r), .f(fv4));

  // MIT code dividers
  logic [QUO_W-1:0] qp, qv, qt;
  mcfe_div u_dp  (.clk(clk), .num(mp2_r),  .den(dp2_r),  .quo(qp));
  mcfe_div u_dv  (.clk(clk), .num(mv2_r),  .den(dv2_r),  .quo(qv));
  mcfe_div u_dt  (.clk(clk), .num(mt2_r),  .den(dt2_r),  .quo(qt));

  // Stage 4: frame for all commands except MIT
  side_t side4;
  always_comb begin
    logic [10:0] nd11;
    nd11       = {3'b0, ctl4_r.nd};
    side4.mit  = 1'b0;
    side4.kp   = kp4_r;
    side4.kd   = kd4_r;
    side4.id   = nd11;
    side4.pay  = '0;
    unique case (ctl4_r.cmd)
      CMD_ENABLE:  side4.pay = 64'hFFFF_FFFF_FFFF_FFFC;
      CMD_DISABLE: side4.pay = 64'hFFFF_FFFF_FFFF_FFFD;
      CMD_ZERO:    side4.pay = 64'hFFFF_FFFF_FFFF_FFFE;
      CMD_MIT:     side4.mit = 1'b1;
      CMD_POSVEL: begin
        side4.id  = ID_POSVEL + nd11;
        side4.pay = {le_word(fp4), le_word(fv4)};
      end
      CMD_VEL: begin
        side4.id  = ID_VEL + nd11;
        side4.pay = {le_word(fv4), 32'd0};
      end
      CMD_POSTORQUE: begin
        side4.id  = ID_POSTORQUE + nd11;
        side4.pay = {le_word(fp4), vl4_r, il4_r};
      end
      CMD_READ: begin
        side4.id  = ID_BCAST;
        side4.pay = {ctl4_r.nd, 8'h00, OP_READ, ctl4_r.preg, 32'd0};
      end
      CMD_WRITE: begin
        side4.id  = ID_BCAST;
        side4.pay = {ctl4_r.nd, 8'h00, OP_WRITE, ctl4_r.preg, le_word(ctl4_r.pval)};
      end
      CMD_SAVE: begin
        side4.id  = ID_BCAST;
        side4.pay = {ctl4_r.nd, 8'h00, OP_SAVE, 8'h01, 32'd0};
      end
      default: ;
    endcase
  end

  // Delay line alongside the dividers
  side_t dly_r [DLY];
  logic [DLY-1:0] dvld_r;
  always_ff @(posedge clk) begin
    dly_r[0] <= side4;
    for (int k = 1; k < DLY; k++) begin
      dly_r[k] <= dly_r[k-1];
    end
  end

  // Valid bits
  logic  out_valid_r;
  out_t  out_data_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      dvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[2:0], start & ~busy};
      dvld_r      <= {dvld_r[DLY-2:0], vld_r[3]};
      out_valid_r <= dvld_r[DLY-1];
    end
  end

  // Output register: merge MIT codes
  always_ff @(posedge clk) begin
    out_data_r.frame_id <= dly_r[DLY-1].id;
    if (dly_r[DLY-1].mit) begin
      out_data_r.frame_payload <= {qp, qv[11:0], dly_r[DLY-1].kp, dly_r[DLY-1].kd,
                                   qt[11:0]};
    end else begin
      out_data_r.frame_payload <= dly_r[DLY-1].pay;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== design/mcfe_div.sv =====
// ----------------------------------------------------------------------------
// mcfe_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in QUO_W bits; a zero divisor yields a zero quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mcfe_div
  import mcfe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] lo;
    logic [QUO_W-1:0] q;
    logic [DEN_W-1:0] den;
  } dstage_t;

  dstage_t st_r   [DIV_STEPS];
  dstage_t st_nxt [DIV_STEPS];

  // One compare and subtract per stage
  always_comb begin
    dstage_t    prev;
    logic [DEN_W:0] sh;
    logic           ge;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        prev.rem = num[NUM_W-1:QUO_W];
        prev.lo  = num[QUO_W-1:0];
        prev.q   = '0;
        prev.den = den;
      end else begin
        prev = st_r[k-1];
      end
      sh = {prev.rem, prev.lo[QUO_W-1]};
      ge = (sh >= {1'b0, prev.den});
      st_nxt[k].rem = ge ? DEN_W'(sh - {1'b0, prev.den}) : sh[DEN_W-1:0];
      st_nxt[k].lo  = {prev.lo[QUO_W-2:0], 1'b0};
      st_nxt[k].q   = {prev.q[QUO_W-2:0], ge};
      st_nxt[k].den = prev.den;
    end
  end

  // Advance the stages
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      st_r[k] <= st_nxt[k];
    end
  end

  assign quo = (st_r[DIV_STEPS-1].den == '0) ? '0 : st_r[DIV_STEPS-1].q;

endmodule
`default_nettype wire

// ===== design/mcfe_f32.sv =====
// ----------------------------------------------------------------------------
// mcfe_f32
// Three-stage conversion of a signed Q10.16 value (magnitude below 2^25) to
// IEEE single precision, round to nearest even.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mcfe_f32
  import mcfe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic signed [DEN_W-1:0] x,
  output logic [31:0]            f
);

  logic        a_sign_r, b_sign_r;
  logic        a_zero_r, b_zero_r;
  logic [24:0] a_mag_r;
  logic [4:0]  a_pos_r, b_pos_r;
  logic [24:0] b_norm_r;
  logic [31:0] f_r;

  logic [24:0] mag_nxt;
  logic [4:0]  pos_nxt;

  // Take magnitude and find the leading one
  always_comb begin
    logic [DEN_W-1:0] ax;
    ax      = x[DEN_W-1] ? DEN_W'(-x) : DEN_W'(x);
    mag_nxt = ax[24:0];
    pos_nxt = '0;
    for (int i = 0; i < 25; i++) begin
      if (mag_nxt[i]) pos_nxt = 5'(i);
    end
  end

  // Round and pack
  logic [24:0] mant_sum;
  logic [7:0]  ex_base;
  logic [31:0] f_nxt;
  always_comb begin
    mant_sum = {1'b0, b_norm_r[24:1]} + 25'(b_norm_r[0] & b_norm_r[1]);
    ex_base  = 8'({3'b0, b_pos_r}) + 8'd111 + 8'(mant_sum[24]);
    f_nxt    = {b_sign_r, ex_base, mant_sum[24] ? 23'd0 : mant_sum[22:0]};
    if (b_zero_r) f_nxt = '0;
  end

  always_ff @(posedge clk) begin
    a_sign_r <= x[DEN_W-1];
    a_zero_r <= (x == '0);
    a_mag_r  <= mag_nxt;
    a_pos_r  <= pos_nxt;
    b_sign_r <= a_sign_r;
    b_zero_r <= a_zero_r;
    b_pos_r  <= a_pos_r;
    b_norm_r <= 25'(a_mag_r << (5'd24 - a_pos_r));
    f_r      <= f_nxt;
  end

  assign f = f_r;

endmodule
`default_nettype wire

// ===== verif/tb_motor_command_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_motor_command_frame_encoder
// Self-checking bench for the motor command frame encoder. A local frame
// predictor computes the expected frame of every accepted command and keeps
// it in a FIFO. A monitor compares each output frame with the oldest entry.
// The run covers directed corner cases and random commands under several
// register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_motor_command_frame_encoder;
  import mcfe_pkg::*;

  localparam int LATENCY    = 19;
  localparam int WDOG_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_data;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;

  // Shadow copy of the configuration registers
  logic [7:0]       node_q;
  logic [LIM_W-1:0] pos_lim_q;
  logic [LIM_W-1:0] vel_lim_q;
  logic [LIM_W-1:0] trq_lim_q;

  out_t frame_fifo[$];
  int   err_cnt;
  int   idle_pct;
  int   wdog_cnt;

  motor_command_frame_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Clamp a signed value into [lo, hi]
  function automatic longint clip(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // Map a clamped value linearly onto a code of the given width, rounding down
  function automatic longint lin_code(longint x, longint lo, longint hi, int bits);
    longint span;
    span = hi - lo;
    if (span == 0) return 0;
    return ((x - lo) * ((longint'(1) << bits) - 1)) / span;
  endfunction

  // Q16.16 to single precision, round to nearest even
  function automatic logic [31:0] q16_float(longint v);
    logic        sgn;
    longint      m;
    longint      mant;
    longint      rem;
    longint      half;
    int          msb;
    int          ex;
    int          sh;
    if (v == 0) return 32'd0;
    sgn = (v < 0);
    m   = sgn ? -v : v;
    msb = 0;
    for (int i = 0; i < 63; i++) if (m[i]) msb = i;
    ex = msb - 16 + 127;
    if (msb > 23) begin
      sh   = msb - 23;
      rem  = m & ((longint'(1) << sh) - 1);
      half = longint'(1) << (sh - 1);
      mant = m >>> sh;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == (longint'(1) << 24)) begin
        mant = mant >>> 1;
        ex++;
      end
    end else begin
      mant = m << (23 - msb);
    end
    return {sgn, ex[7:0], mant[22:0]};
  endfunction

  function automatic logic [31:0] byte_swap(logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic longint sat_u16(longint v);
    return (v > 65535) ? 65535 : v;
  endfunction

  // Predict the frame for one command under the current registers
  function automatic out_t encode_frame(in_t c);
    out_t   f;
    longint lp, lv, lt, p, v, t, kp, kd, vl, il;
    lp = pos_lim_q;
    lv = vel_lim_q;
    lt = trq_lim_q;
    p  = clip(longint'(c.position), -lp, lp);
    v  = longint'(c.velocity);
    t  = longint'(c.torque);
    f.frame_id      = {3'd0, node_q};
    f.frame_payload = '0;
    case (c.cmd)
      CMD_ENABLE:  f.frame_payload = 64'hFFFF_FFFF_FFFF_FFFC;
      CMD_DISABLE: f.frame_payload = 64'hFFFF_FFFF_FFFF_FFFD;
      CMD_ZERO:    f.frame_payload = 64'hFFFF_FFFF_FFFF_FFFE;
      CMD_MIT: begin
        kp = clip(longint'(c.stiffness), 0, KP_MAX);
        kd = clip(longint'(c.damping), 0, KD_MAX);
        v  = clip(v, -lv, lv);
        t  = clip(t, -lt, lt);
        f.frame_payload = (64'(lin_code(p, -lp, lp, 16)) << 48) |
                          (64'(lin_code(v, -lv, lv, 12)) << 36) |
                          (64'(lin_code(kp, 0, KP_MAX, 12)) << 24) |
                          (64'(lin_code(kd, 0, KD_MAX, 12)) << 12) |
                          64'(lin_code(t, -lt, lt, 12));
      end
      CMD_POSVEL: begin
        v = clip(v, -lv, lv);
        f.frame_id      = ID_POSVEL + node_q;
        f.frame_payload = {byte_swap(q16_float(p)), byte_swap(q16_float(v))};
      end
      CMD_VEL: begin
        v = clip(v, -lv, lv);
        f.frame_id      = ID_VEL + node_q;
        f.frame_payload = {byte_swap(q16_float(v)), 32'd0};
      end
      CMD_POSTORQUE: begin
        v  = clip(v, 0, lv);
        t  = clip(t, 0, lt);
        vl = sat_u16((v * 100) >>> 16);
        il = sat_u16((t * 10000) >>> 16);
        f.frame_id      = ID_POSTORQUE + node_q;
        f.frame_payload = {byte_swap(q16_float(p)), vl[15:0], il[15:0]};
      end
      CMD_READ: begin
        f.frame_id      = ID_BCAST;
        f.frame_payload = {node_q, 8'h00, OP_READ, c.param_reg, 32'd0};
      end
      CMD_WRITE: begin
        f.frame_id      = ID_BCAST;
        f.frame_payload = {node_q, 8'h00, OP_WRITE, c.param_reg,
                           byte_swap(c.param_value)};
      end
      CMD_SAVE: begin
        f.frame_id      = ID_BCAST;
        f.frame_payload = {node_q, 8'h00, OP_SAVE, 8'h01, 32'd0};
      end
      default: f.frame_payload = '0;
    endcase
    return f;
  endfunction

  // Compare each output frame with the oldest prediction
  always @(posedge clk) begin
    out_t exp_f;
    if (rst_n && out_valid) begin
      if (frame_fifo.size() == 0) begin
        $display("%0t: unexpected frame, expected none, actual %h", $time, out_data);
        err_cnt++;
      end else begin
        exp_f = frame_fifo.pop_front();
        if (out_data.frame_id !== exp_f.frame_id) begin
          $display("%0t: frame_id expected %h actual %h", $time,
                   exp_f.frame_id, out_data.frame_id);
          err_cnt++;
        end
        if (out_data.frame_payload !== exp_f.frame_payload) begin
          $display("%0t: frame_payload expected %h actual %h", $time,
                   exp_f.frame_payload, out_data.frame_payload);
          err_cnt++;
        end
      end
    end
  end

  // Count cycles with no transaction; abort when stuck
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      wdog_cnt <= 0;
    else
      wdog_cnt <= wdog_cnt + 1;
    if (wdog_cnt >= WDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Send one command and record its predicted frame; start stays high
  // so that the next command can follow at once
  task automatic send_cmd(in_t c);
    while (($urandom_range(99, 0)) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    frame_fifo.push_back(encode_frame(c));
  endtask

  // Drop start, wait for all frames, then let the pipeline drain
  task automatic drain();
    start <= 1'b0;
    while (frame_fifo.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Write one register; block must be idle, valid stays high afterwards
  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_NODE_ID:        node_q    = val[7:0];
      CFG_POSITION_LIMIT: pos_lim_q = val[LIM_W-1:0];
      CFG_VELOCITY_LIMIT: vel_lim_q = val[LIM_W-1:0];
      CFG_TORQUE_LIMIT:   trq_lim_q = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [7:0] nd, int lp, int lv, int lt);
    drain();
    write_reg(CFG_NODE_ID, nd);
    write_reg(CFG_POSITION_LIMIT, lp);
    write_reg(CFG_VELOCITY_LIMIT, lv);
    write_reg(CFG_TORQUE_LIMIT, lt);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5, 0))
      0: return $urandom;
      1: return {{16{$urandom_range(1, 0) == 1}}, 16'($urandom)};
      2: return 32'($urandom_range(2000000, 0));
      3: return -32'($urandom_range(2000000, 0));
      4: return {$urandom_range(1, 0) == 1, 31'd0} | 32'($urandom_range(3, 0));
      default: return {{8{$urandom_range(1, 0) == 1}}, 24'($urandom)};
    endcase
  endfunction

  function automatic in_t rand_cmd();
    in_t c;
    c.cmd         = 4'($urandom_range(15, 0));
    if ($urandom_range(9, 0) < 6) c.cmd = 4'(CMD_MIT + $urandom_range(3, 0));
    c.position    = rand_word();
    c.velocity    = rand_word();
    c.torque      = rand_word();
    c.stiffness   = rand_word();
    c.damping     = rand_word();
    c.param_reg   = 8'($urandom);
    c.param_value = $urandom;
    return c;
  endfunction

  // Every command code plus field extremes under the current registers
  task automatic test_directed();
    in_t c;
    for (int k = 0; k < 16; k++) begin
      c = '{cmd: 4'(k), position: 32'sh8000_0000, velocity: 32'sh7FFF_FFFF,
            torque: 32'sh8000_0000, stiffness: 32'sh7FFF_FFFF,
            damping: 32'sh7FFF_FFFF, param_reg: 8'hFF, param_value: 32'hFFFF_FFFF};
      send_cmd(c);
    end
    for (int k = CMD_MIT; k <= CMD_POSTORQUE; k++) begin
      c = '{cmd: 4'(k), position: 32'sh7FFF_FFFF, velocity: 32'sh8000_0000,
            torque: 32'sh7FFF_FFFF, stiffness: 32'sh8000_0000,
            damping: 32'sh8000_0000, param_reg: 8'h00, param_value: 32'h0};
      send_cmd(c);
      c = '{cmd: 4'(k), position: 0, velocity: 0, torque: 0, stiffness: 0,
            damping: 0, param_reg: 8'h00, param_value: 32'h0};
      send_cmd(c);
    end
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      idle_pct = (i % 400 < 150) ? 0 : 10;
      send_cmd(rand_cmd());
    end
    idle_pct = 10;
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    err_cnt   = 0;
    idle_pct  = 10;
    node_q    = 8'd1;
    pos_lim_q = 25'd819200;
    vel_lim_q = 25'd1966080;
    trq_lim_q = 25'd655360;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(400);
    // Largest limits and top node id
    set_regs(8'hFF, 33554431, 33554431, 33554431);
    test_directed();
    test_random(400);
    // Smallest nonzero limits, node zero
    set_regs(8'h00, 1, 1, 1);
    test_random(300);
    // Zero limits: values clamp to zero and spans vanish
    set_regs(8'h5A, 0, 0, 0);
    test_random(200);
    set_regs(8'($urandom), $urandom_range(33554431, 1), $urandom_range(33554431, 1),
             $urandom_range(33554431, 1));
    test_random(550);

    drain();
    if (err_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
